// ----- rtl/core/mtf_pkg.sv -----
`timescale 1ns / 1ps
// Package for the byte move-to-front codec core.
// Holds list geometry constants, the sequencer state type and the cell control struct.
// No dependencies.
package mtf_pkg;

  // Recency list geometry: one cell per byte value.
  localparam int unsigned ListSize  = 256;
  localparam int unsigned SymW      = 8;
  // The match reduction is registered once per group of cells.
  localparam int unsigned GroupSize = 16;
  localparam int unsigned NumGroups = ListSize / GroupSize;

  // Mode register codes.
  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  // Item sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_RED,
    ST_SHF
  } mtf_state_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic load_id;
    logic shift;
    logic mode;
  } mtf_cell_ctl_t;

endpackage

// ----- rtl/core/mtf_cell.sv -----
`timescale 1ns / 1ps
// One cell of the move-to-front recency list: holds the byte at one list position.
// Depends on mtf_pkg for widths and the control struct.
module mtf_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mtf_pkg::mtf_cell_ctl_t     ctl,
  input  logic [mtf_pkg::SymW-1:0]   key,
  input  logic [mtf_pkg::SymW-1:0]   pos,
  input  logic [mtf_pkg::SymW-1:0]   sym,
  input  logic [mtf_pkg::SymW-1:0]   prev_data,
  output logic [mtf_pkg::SymW-1:0]   data,
  output logic [mtf_pkg::SymW-1:0]   contrib
);

  localparam logic [mtf_pkg::SymW-1:0] IdxB = Idx[mtf_pkg::SymW-1:0];

  logic [mtf_pkg::SymW-1:0] data_r;
  logic [mtf_pkg::SymW-1:0] data_nxt;
  logic                     hit;

  // Encode matches on the stored byte, decode matches on this cell's position.
  // A hit cell offers the other half of the pair to the reduction.
  always_comb begin
    if (ctl.mode == mtf_pkg::ModeDecode) begin
      hit     = (IdxB == key);
      contrib = hit ? data_r : '0;
    end else begin
      hit     = (data_r == key);
      contrib = hit ? IdxB : '0;
    end
  end

  // Identity reload, or one step of the move to front: the front cell takes the
  // promoted byte, cells up to the hit position take their neighbor's byte.
  always_comb begin
    data_nxt = data_r;
    if (ctl.load_id) begin
      data_nxt = IdxB;
    end else if (ctl.shift) begin
      if (Idx == 0) begin
        data_nxt = sym;
      end else if (IdxB <= pos) begin
        data_nxt = prev_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= IdxB;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data = data_r;

endmodule

// ----- rtl/core/move_to_front_codec_core.sv -----
`timescale 1ns / 1ps
// Top level of the byte move-to-front codec: cell row, match reduction and sequencer.
// Depends on mtf_pkg and mtf_cell.
//
// Byte move-to-front codec. The recency list lives in a row of 256 cells, one per
// position, and starts in identity order after reset. With mode 0 each input byte
// yields its list position, with mode 1 each input position yields the byte held
// there; either way that byte then moves to the front. A set restart flag on an item
// restores identity order before the item is handled. Each item goes through accept,
// a parallel compare in all cells with a registered OR per group of 16 cells, the final
// OR of the 16 group results into the output register, and one shift pass along the cell
// row. The input is taken again in the cycle after the shift. If a previous result is
// still unclaimed, the item waits in the reduction step until the output register frees.
// The user writes mode through cfg_wr_en only while the core is idle; it is not enforced.
module move_to_front_codec_core (
  input  logic       clk,
  input  logic       rst_n,
  // Configuration: bit 0 mode (0 encode, 1 decode).
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  // Input stream. tdata: [7:0] value. tuser: [0] restart.
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  // Result stream. tdata: [7:0] result.
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata
);

  localparam int unsigned SymW = mtf_pkg::SymW;

  mtf_pkg::mtf_state_t    state_r, state_nxt;
  mtf_pkg::mtf_cell_ctl_t ctl;

  logic            mode_r;
  logic [SymW-1:0] key_r;
  logic [SymW-1:0] pos_r, pos_nxt;
  logic [SymW-1:0] sym_r, sym_nxt;
  logic [SymW-1:0] out_data_r;
  logic            out_valid_r, out_valid_nxt;
  logic            in_xfer;
  logic            load_out;

  logic [SymW-1:0] cell_data    [mtf_pkg::ListSize];
  logic [SymW-1:0] cell_contrib [mtf_pkg::ListSize];
  logic [SymW-1:0] grp_or       [mtf_pkg::NumGroups];
  logic [SymW-1:0] grp_r        [mtf_pkg::NumGroups];
  logic [SymW-1:0] found;

  assign in_xfer = in_tvalid && in_tready;

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mtf_pkg::ModeEncode;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // Cell control: identity reload on a restart transfer, shift in the last step.
  always_comb begin
    ctl.load_id = in_xfer && in_tuser;
    ctl.shift   = (state_r == mtf_pkg::ST_SHF);
    ctl.mode    = mode_r;
  end

  // The cell row; on a shift, cells 1 to the hit position take their lower neighbor's byte.
  for (genvar i = 0; i < mtf_pkg::ListSize; i++) begin : g_cell
    logic [SymW-1:0] prev;
    if (i == 0) begin : g_front
      assign prev = '0;
    end else begin : g_rest
      assign prev = cell_data[i-1];
    end
    mtf_cell #(
      .Idx(i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .key      (key_r),
      .pos      (pos_r),
      .sym      (sym_r),
      .prev_data(prev),
      .data     (cell_data[i]),
      .contrib  (cell_contrib[i])
    );
  end

  // First reduction level: OR of the cell contributions inside each group; only one cell hits.
  always_comb begin
    for (int g = 0; g < mtf_pkg::NumGroups; g++) begin
      grp_or[g] = '0;
      for (int k = 0; k < mtf_pkg::GroupSize; k++) begin
        grp_or[g] = grp_or[g] | cell_contrib[g*mtf_pkg::GroupSize + k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == mtf_pkg::ST_CMP) begin
      grp_r <= grp_or;
    end
  end

  // Second reduction level over the registered group results.
  always_comb begin
    found = '0;
    for (int g = 0; g < mtf_pkg::NumGroups; g++) begin
      found = found | grp_r[g];
    end
  end

  // The reduction yields the position when encoding and the byte when decoding.
  always_comb begin
    if (mode_r == mtf_pkg::ModeDecode) begin
      pos_nxt = key_r;
      sym_nxt = found;
    end else begin
      pos_nxt = found;
      sym_nxt = key_r;
    end
  end

  // Sequencer: next state and output register control.
  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      mtf_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = mtf_pkg::ST_CMP;
        end
      end
      mtf_pkg::ST_CMP: begin
        state_nxt = mtf_pkg::ST_RED;
      end
      mtf_pkg::ST_RED: begin
        if (!out_valid_r || out_tready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = mtf_pkg::ST_SHF;
        end
      end
      mtf_pkg::ST_SHF: begin
        state_nxt = mtf_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mtf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      key_r <= in_tdata;
    end
    if (load_out) begin
      pos_r      <= pos_nxt;
      sym_r      <= sym_nxt;
      out_data_r <= (mode_r == mtf_pkg::ModeDecode) ? sym_nxt : pos_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/core/mtf_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the move-to-front codec core, bound to the top level.
// Depends on move_to_front_codec_core ports only.
module mtf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // A held result keeps its data until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The core works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while an item is in flight");

  // Nothing is shown right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // After a restart, value zero maps to zero in either mode.
  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser && (in_tdata == 8'd0) && !out_tvalid
      |-> ##3 (out_tvalid && (out_tdata == 8'd0)))
    else $error("restart item with value zero gave a wrong result");

endmodule

bind move_to_front_codec_core mtf_checker u_mtf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
